### src/u8v_pkg.sv
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
`default_nettype none

package u8v_pkg;

	// Width of one raw byte and of the padded result word.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned RESULT_W = 8;

	// Byte class masks and patterns.
	localparam logic [BYTE_W-1:0] ASCII_MAX     = 8'h7F;
	localparam logic [BYTE_W-1:0] MASK_CONT     = 8'hC0;
	localparam logic [BYTE_W-1:0] PAT_CONT      = 8'h80;
	localparam logic [BYTE_W-1:0] MASK_LEAD2    = 8'hE0;
	localparam logic [BYTE_W-1:0] PAT_LEAD2     = 8'hC0;
	localparam logic [BYTE_W-1:0] MASK_OVERLONG = 8'hFE;
	localparam logic [BYTE_W-1:0] PAT_OVERLONG  = 8'hC0;
	localparam logic [BYTE_W-1:0] MASK_LEAD3    = 8'hF0;
	localparam logic [BYTE_W-1:0] PAT_LEAD3     = 8'hE0;
	localparam logic [BYTE_W-1:0] MASK_LEAD4    = 8'hF8;
	localparam logic [BYTE_W-1:0] PAT_LEAD4     = 8'hF0;

	// Continuation counts owed after each lead byte.
	localparam logic [1:0] OWE_NONE  = 2'd0;
	localparam logic [1:0] OWE_ONE   = 2'd1;
	localparam logic [1:0] OWE_TWO   = 2'd2;
	localparam logic [1:0] OWE_THREE = 2'd3;

	// Decoder state carried from one byte to the next.
	typedef struct packed {
		logic [1:0] owed;
		logic       err;
	} u8v_state_t;

	// Per-byte result flags.
	typedef struct packed {
		logic buffer_valid;
		logic ok_so_far;
	} u8v_result_t;

endpackage : u8v_pkg

`default_nettype wire

### src/u8v_step.sv
// ----------------------------------------------------------------------------
// u8v_step
// Combinational next-state and result logic for one byte of the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module u8v_step (
	input  wire logic [u8v_pkg::BYTE_W-1:0] byte_value,
	input  wire logic                       last_byte,
	input  wire u8v_pkg::u8v_state_t        cur_state,
	output u8v_pkg::u8v_state_t             nxt_state,
	output u8v_pkg::u8v_result_t            result
);
	import u8v_pkg::*;

	u8v_state_t upd;

	// Classify the byte against the current decoder state.
	always_comb begin
		upd = cur_state;
		if (!cur_state.err) begin
			priority if (cur_state.owed != OWE_NONE) begin
				if ((byte_value & MASK_CONT) == PAT_CONT) begin
					upd.owed = cur_state.owed - 2'd1;
				end else begin
					upd.err = 1'b1;
				end
			end else if (byte_value <= ASCII_MAX) begin
				upd.owed = OWE_NONE;
			end else if ((byte_value & MASK_LEAD2) == PAT_LEAD2) begin
				if ((byte_value & MASK_OVERLONG) == PAT_OVERLONG) begin
					upd.err = 1'b1;
				end else begin
					upd.owed = OWE_ONE;
				end
			end else if ((byte_value & MASK_LEAD3) == PAT_LEAD3) begin
				upd.owed = OWE_TWO;
			end else if ((byte_value & MASK_LEAD4) == PAT_LEAD4) begin
				upd.owed = OWE_THREE;
			end else begin
				upd.err = 1'b1;
			end
			if (upd.err) begin
				upd.owed = OWE_NONE;
			end
		end
	end

	// Result flags and the state handed to the next byte.
	always_comb begin
		result.ok_so_far    = ~upd.err;
		result.buffer_valid = last_byte & ~upd.err & (upd.owed == OWE_NONE);
		if (last_byte) begin
			nxt_state = '0;
		end else begin
			nxt_state = upd;
		end
	end

endmodule : u8v_step

`default_nettype wire

### src/utf8_stream_validator_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_top
// Checks a UTF-8 byte stream and returns one result per byte.
// ----------------------------------------------------------------------------
// The block takes one byte per transaction, with tlast marking the final byte
// of a buffer, and returns exactly one result transaction per byte in order.
// It sustains one byte per clock cycle while the output side is ready; each
// byte passes through an input register and then a result register, which
// offers its result until the output side is ready to take it. The input
// stalls only while both registers are full and the output side is not
// ready. The decoder state
// (owed continuation bytes and a sticky error flag) updates as a byte moves
// from the input register to the result register, and it clears after the
// byte marked last. Lead bytes 0xC0 and 0xC1 are rejected as overlong; three-
// and four-byte forms get no overlong, surrogate or range checks.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_validator_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Byte stream in.
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [u8v_pkg::BYTE_W-1:0]   s_tdata,  // [7:0] byte_value
	input  wire logic                         s_tlast,  // last_byte
	// Result stream out.
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [u8v_pkg::RESULT_W-1:0]      m_tdata,  // [0] ok_so_far, [1] buffer_valid
	output logic                              m_tlast   // buffer_done
);
	import u8v_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                last_s1;
	logic                valid_s2;
	u8v_result_t         result_s2;
	logic                last_s2;
	u8v_state_t          state_q;
	u8v_state_t          state_nxt;
	u8v_result_t         result_nxt;
	logic                adv_s2;
	logic                adv_s1;

	// Handshake: each stage moves when the stage after it has room.
	assign adv_s2   = ~valid_s2 | m_tready;
	assign adv_s1   = valid_s1 & adv_s2;
	assign s_tready = ~valid_s1 | adv_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Per-byte decode step.
	u8v_step u_step (
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.cur_state  (state_q),
		.nxt_state  (state_nxt),
		.result     (result_nxt)
	);

	// Decoder state advances with each byte that reaches the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result_nxt;
			last_s2   <= last_s1;
		end
	end

	// Output transaction fields, padded to a whole byte.
	assign m_tvalid = valid_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {{(RESULT_W-2){1'b0}}, result_s2.buffer_valid, result_s2.ok_so_far};

endmodule : utf8_stream_validator_top

`default_nettype wire

### verif/utf8_stream_validator_top_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_top_test
// Self-checking stream test of the UTF-8 validator.
// ----------------------------------------------------------------------------
// Byte buffers go in on the slave stream, and every result transaction is
// checked against a cycle-free decoder kept in the bench. A short directed set
// covers the edge cases first: ASCII limits, overlong two-byte leads, invalid
// leads, stray and missing continuation bytes, and a truncated sequence.
// Random buffers follow. Most of them are well-formed characters with random
// payloads, mixed with bad leads, truncations and raw noise. The random part
// runs under three idle mixes. A long output stall fills the block while
// bytes keep coming.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_validator_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import u8v_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned LONG_HOLD   = 300;

	// One raw byte waiting to go out.
	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              last;
	} text_byte_t;

	// The three flags that every byte produces.
	typedef struct {
		logic ok_so_far;
		logic buffer_done;
		logic buffer_valid;
	} verdict_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata  = '0;
	logic                s_tlast  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [RESULT_W-1:0] m_tdata;
	logic                m_tlast;

	text_byte_t  pending_bytes[$];
	verdict_t    expected_verdicts[$];
	u8v_state_t  decoder = '{owed: OWE_NONE, err: 1'b0};

	int unsigned sender_idle_pct   = 0;
	int unsigned receiver_idle_pct = 0;
	int unsigned long_hold_req     = 0;
	int unsigned long_hold_seen    = 0;
	int unsigned hold_left         = 0;
	int unsigned cycle_count       = 0;
	int unsigned mismatch_count    = 0;
	int unsigned bytes_sent        = 0;
	int unsigned valid_buffers     = 0;
	int unsigned error_buffers     = 0;
	int unsigned truncated_buffers = 0;

	utf8_stream_validator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// Decode one byte and return the flags that the block should give for it.
	function automatic verdict_t judge_byte(input logic [BYTE_W-1:0] b, input logic last);
		verdict_t v;
		if (!decoder.err) begin
			if (decoder.owed != OWE_NONE) begin
				if ((b & MASK_CONT) == PAT_CONT) begin
					decoder.owed = decoder.owed - 2'd1;
				end else begin
					decoder.err = 1'b1;
				end
			end else if (b > ASCII_MAX) begin
				if ((b & MASK_LEAD2) == PAT_LEAD2) begin
					if ((b & MASK_OVERLONG) == PAT_OVERLONG) begin
						decoder.err = 1'b1;
					end else begin
						decoder.owed = OWE_ONE;
					end
				end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
					decoder.owed = OWE_TWO;
				end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
					decoder.owed = OWE_THREE;
				end else begin
					decoder.err = 1'b1;
				end
			end
			// An error drops whatever was still owed.
			if (decoder.err) begin
				decoder.owed = OWE_NONE;
			end
		end
		v.ok_so_far    = !decoder.err;
		v.buffer_done  = last;
		v.buffer_valid = last && !decoder.err && decoder.owed == OWE_NONE;
		if (last) begin
			decoder.owed = OWE_NONE;
			decoder.err  = 1'b0;
		end
		return v;
	endfunction

	function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic last);
		text_byte_t t;
		t.value = b;
		t.last  = last;
		pending_bytes.push_back(t);
	endfunction

	// A lead byte with a random payload for a character of len bytes.
	function automatic logic [BYTE_W-1:0] lead_for(input int len);
		case (len)
			1: begin
				return {1'b0, 7'($urandom)};
			end
			2: begin
				return {3'b110, 5'($urandom_range(2, 31))};
			end
			3: begin
				return {4'b1110, 4'($urandom)};
			end
			default: begin
				return {5'b11110, 3'($urandom)};
			end
		endcase
	endfunction

	// Queue one random buffer and return how many bytes it holds.
	function automatic int add_buffer();
		logic [BYTE_W-1:0] text[$];
		int n_chars;
		int len;
		int n_cont;
		int pick;
		n_chars = $urandom_range(1, 6);
		for (int c = 0; c < n_chars; c++) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				// Well-formed character.
				len = $urandom_range(1, 4);
				text.push_back(lead_for(len));
				n_cont = len - 1;
			end else if (pick < 88) begin
				// Overlong, stray continuation or impossible lead.
				case ($urandom_range(2))
					0: text.push_back({7'b1100000, 1'($urandom)});
					1: text.push_back({2'b10, 6'($urandom)});
					default: text.push_back({5'b11111, 3'($urandom)});
				endcase
				n_cont = 0;
			end else if (pick < 94) begin
				// Multi-byte character cut short.
				len = $urandom_range(2, 4);
				text.push_back(lead_for(len));
				n_cont = $urandom_range(0, len - 2);
			end else begin
				text.push_back(8'($urandom));
				n_cont = 0;
			end
			for (int k = 0; k < n_cont; k++) begin
				text.push_back({2'b10, 6'($urandom)});
			end
		end
		foreach (text[i]) begin
			push_byte(text[i], i == text.size() - 1);
		end
		return text.size();
	endfunction

	function automatic void add_random_bytes(input int target);
		int added;
		added = 0;
		while (added < target) begin
			added += add_buffer();
		end
	endfunction

	function automatic void check_field(input string name, input logic want, input logic got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Wait until every queued byte has gone in and every result has come back.
	task automatic drain();
		do begin
			@(posedge clk);
		end while (pending_bytes.size() != 0 || s_tvalid || expected_verdicts.size() != 0);
	endtask

	// Byte driver: record each accepted transaction, then offer the next byte.
	always @(posedge clk) begin : drive_bytes
		text_byte_t t;
		verdict_t   v;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				v = judge_byte(s_tdata, s_tlast);
				expected_verdicts.push_back(v);
				bytes_sent++;
				if (v.buffer_done) begin
					if (v.buffer_valid) begin
						valid_buffers++;
					end else if (!v.ok_so_far) begin
						error_buffers++;
					end else begin
						truncated_buffers++;
					end
				end
			end
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					t = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= t.value;
					s_tlast  <= t.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result sink: random back-pressure, plus one long stall on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold_seen != long_hold_req) begin
				long_hold_seen = long_hold_req;
				hold_left      = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		verdict_t v;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual tdata %h tlast %0b",
					$time, m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				v = expected_verdicts.pop_front();
				check_field("ok_so_far", v.ok_so_far, m_tdata[0]);
				check_field("buffer_valid", v.buffer_valid, m_tdata[1]);
				check_field("buffer_done", v.buffer_done, m_tlast);
				if (m_tdata[RESULT_W-1:2] !== '0) begin
					$display("%0t ns: tdata padding mismatch, expected 0, actual %h",
						$time, m_tdata[RESULT_W-1:2]);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// Stimulus sequence and final verdict.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed edge cases: ASCII limits, good two- to four-byte forms.
		push_byte(8'h00, 1'b1);
		push_byte(8'h7F, 1'b1);
		push_byte(8'hC2, 1'b0); push_byte(8'hBF, 1'b1);
		push_byte(8'hEF, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'hBF, 1'b1);
		push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'h80, 1'b0);
		push_byte(8'h80, 1'b1);
		// Overlong leads; the byte after an error is not examined.
		push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b1);
		push_byte(8'hC1, 1'b1);
		// Impossible leads and a stray continuation byte.
		push_byte(8'hFF, 1'b1);
		push_byte(8'hF8, 1'b1);
		push_byte(8'h80, 1'b1);
		// Missing continuation, then a buffer that ends mid-character.
		push_byte(8'hE0, 1'b0); push_byte(8'h41, 1'b1);
		push_byte(8'hF0, 1'b0); push_byte(8'h80, 1'b1);
		drain();

		// Random buffers: sender idles less than receiver.
		sender_idle_pct   = 26;
		receiver_idle_pct = 55;
		add_random_bytes(520);
		drain();

		// The other way round.
		sender_idle_pct   = 55;
		receiver_idle_pct = 26;
		add_random_bytes(520);
		drain();

		// Full rate, with one long output stall while bytes keep coming.
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		add_random_bytes(590);
		long_hold_req++;
		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d bytes: %0d valid buffers, %0d with errors, %0d truncated,",
			bytes_sent, valid_buffers, error_buffers, truncated_buffers);
		$display("under three idle mixes and one long result stall.");
		if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule : utf8_stream_validator_top_test

`default_nettype wire

### sim.f
src/u8v_pkg.sv
src/u8v_step.sv
src/utf8_stream_validator_top.sv
verif/utf8_stream_validator_top_test.sv
